// ----- rtl/core/bcr_pkg.sv -----
// Shared constants, register codes and types for the bisection cubic root finder.
package bcr_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int LIMB_W          = 32;
  localparam int ITER_W          = 16;
  localparam int CFG_INDEX_W     = 3;

  localparam logic signed [31:0] RST_COEF_CUBIC  = -32'sd68629;
  localparam logic signed [31:0] RST_COEF_SQUARE = 32'sd617662;
  localparam logic signed [31:0] RST_COEF_LINEAR = 32'sd0;
  localparam logic signed [31:0] RST_COEF_CONST  = -32'sd1966080;
  localparam logic [31:0]        RST_TOLERANCE   = 32'd1;
  localparam logic [ITER_W-1:0]  RST_MAX_ITER    = 16'd1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COEF_CUBIC  = 3'd0,
    REG_COEF_SQUARE = 3'd1,
    REG_COEF_LINEAR = 3'd2,
    REG_COEF_CONST  = 3'd3,
    REG_TOLERANCE   = 3'd4,
    REG_MAX_ITER    = 3'd5
  } cfg_reg_t;

  // Status of one polynomial evaluation, valid in the cycle done is high.
  typedef struct packed {
    logic done;
    logic zero;
    logic neg;
  } bcr_sign_t;

endpackage

// ----- rtl/core/bcr_cell.sv -----
// One limb cell of the accumulator chain: loads in parallel or takes its neighbor's limb.
module bcr_cell
  import bcr_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              shift,
  input  logic [LIMB_W-1:0] load_val,
  input  logic [LIMB_W-1:0] shift_in,
  output logic [LIMB_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_val;
    end else if (shift) begin
      q <= shift_in;
    end
  end

endmodule

// ----- rtl/core/bcr_poly.sv -----
// Exact Horner evaluation of the cubic, one limb a cycle through a ring of limb cells.
module bcr_poly
  import bcr_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] x,
  input  logic signed [VALUE_WIDTH-1:0] coef_cubic,
  input  logic signed [VALUE_WIDTH-1:0] coef_square,
  input  logic signed [VALUE_WIDTH-1:0] coef_linear,
  input  logic signed [VALUE_WIDTH-1:0] coef_const,
  output bcr_sign_t                     res
);

  localparam int W      = VALUE_WIDTH;
  localparam int NLIMB  = (4 * W + 3 * FRAC_BITS + LIMB_W + 3) / LIMB_W;
  localparam int ACC_W  = NLIMB * LIMB_W;
  localparam int IDX_W  = $clog2(NLIMB);
  localparam int T_W    = LIMB_W + W + 2;

  typedef enum logic [1:0] {
    P_SQUARE,
    P_LINEAR,
    P_CONST
  } pass_t;

  pass_t                   pass;
  logic [IDX_W-1:0]        idx;
  logic                    busy;
  logic                    nz;
  logic signed [W+1:0]     carry;
  logic signed [W-1:0]     xr;

  logic [LIMB_W-1:0]       cell_q [NLIMB];
  logic [ACC_W-1:0]        init_full;
  logic [ACC_W-1:0]        add_full;
  logic [LIMB_W-1:0]       add_limb;
  logic signed [LIMB_W+W:0] prod;
  logic signed [T_W-1:0]   t;
  logic [LIMB_W-1:0]       mac_out;

  assign init_full = {{(ACC_W-W){coef_cubic[W-1]}}, coef_cubic};

  always_comb begin
    case (pass)
      P_SQUARE: add_full = {{(ACC_W-W){coef_square[W-1]}}, coef_square} << FRAC_BITS;
      P_LINEAR: add_full = {{(ACC_W-W){coef_linear[W-1]}}, coef_linear} << (2 * FRAC_BITS);
      P_CONST:  add_full = {{(ACC_W-W){coef_const[W-1]}}, coef_const} << (3 * FRAC_BITS);
      default:  add_full = '0;
    endcase
  end

  assign add_limb = add_full[idx*LIMB_W +: LIMB_W];

  // Limb times signed x, plus the addend limb and the signed carry from the limb below.
  assign prod    = $signed({1'b0, cell_q[0]}) * xr;
  assign t       = T_W'(prod) + T_W'($signed({1'b0, add_limb})) + T_W'(carry);
  assign mac_out = t[LIMB_W-1:0];

  for (genvar i = 0; i < NLIMB; i++) begin : g_cell
    logic [LIMB_W-1:0] nb;
    if (i == NLIMB - 1) begin : g_top
      assign nb = mac_out;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    bcr_cell u_cell (
      .clk      (clk),
      .load     (start),
      .shift    (busy),
      .load_val (init_full[i*LIMB_W +: LIMB_W]),
      .shift_in (nb),
      .q        (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pass     <= P_SQUARE;
      idx      <= '0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        pass  <= P_SQUARE;
        idx   <= '0;
        carry <= '0;
        nz    <= 1'b0;
        xr    <= x;
      end else if (busy) begin
        carry <= t[T_W-1:LIMB_W];
        if (pass == P_CONST) begin
          nz <= nz | (|mac_out);
        end
        if (idx == IDX_W'(NLIMB - 1)) begin
          idx   <= '0;
          carry <= '0;
          case (pass)
            P_SQUARE: pass <= P_LINEAR;
            P_LINEAR: pass <= P_CONST;
            default: begin
              // The most significant limb leaves the multiplier last.
              busy     <= 1'b0;
              res.done <= 1'b1;
              res.zero <= ~(nz | (|mac_out));
              res.neg  <= mac_out[LIMB_W-1];
            end
          endcase
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/bisection_cubic_root_finder.sv -----
// Bisection root finder for a configurable cubic in signed fixed point.
// Each polynomial evaluation makes a square, a linear and a constant pass over NLIMB limbs,
// NLIMB = (4*W+3*F+35)/32 (6 at Q16.16). An item evaluates the lower end, then the midpoint
// once per bisection step, and skips the midpoint when the lower end is itself a zero.
// The evaluator has a single limb multiplier; one item is worked at a time.
// Synchronous reset restores the reset polynomial, tolerance 1 and a limit of 1000 steps.
module bisection_cubic_root_finder
  import bcr_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [VALUE_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] lower_end,
  input  logic signed [VALUE_WIDTH-1:0] upper_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] root_estimate,
  output logic                          exact_zero,
  output logic                          converged,
  output logic [ITER_W-1:0]             steps_used
);

  localparam int W = VALUE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL_LO,
    S_STEP,
    S_EVAL_MID,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t              state;
  logic signed [W-1:0] coef_cubic, coef_square, coef_linear, coef_const;
  logic [W-2:0]        tolerance;
  logic [ITER_W-1:0]   max_iterations;

  logic signed [W-1:0] lo, hi, root;
  logic                sa_zero, sa_neg, ez, conv;
  logic [ITER_W-1:0]   steps;

  logic signed [W:0]   sum, diff;
  logic [W:0]          span;
  logic signed [W-1:0] mid;
  logic                wide;
  logic                poly_start;
  logic signed [W-1:0] poly_x;
  bcr_sign_t           eval_res;

  assign sum  = {lo[W-1], lo} + {hi[W-1], hi};
  assign mid  = sum[W:1];
  assign diff = {lo[W-1], lo} - {hi[W-1], hi};
  assign span = diff[W] ? (~diff + 1'b1) : diff;
  assign wide = span > {2'b00, tolerance};

  assign in_stall   = (state != S_IDLE);
  assign poly_start = (state == S_IDLE && in_valid) || (state == S_STEP && !sa_zero);
  assign poly_x     = (state == S_IDLE) ? lower_end : mid;

  bcr_poly #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_poly (
    .clk         (clk),
    .rst         (rst),
    .start       (poly_start),
    .x           (poly_x),
    .coef_cubic  (coef_cubic),
    .coef_square (coef_square),
    .coef_linear (coef_linear),
    .coef_const  (coef_const),
    .res         (eval_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_cubic     <= W'(RST_COEF_CUBIC);
      coef_square    <= W'(RST_COEF_SQUARE);
      coef_linear    <= W'(RST_COEF_LINEAR);
      coef_const     <= W'(RST_COEF_CONST);
      tolerance      <= (W-1)'(RST_TOLERANCE);
      max_iterations <= RST_MAX_ITER;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_CUBIC:  coef_cubic     <= cfg_data;
        REG_COEF_SQUARE: coef_square    <= cfg_data;
        REG_COEF_LINEAR: coef_linear    <= cfg_data;
        REG_COEF_CONST:  coef_const     <= cfg_data;
        REG_TOLERANCE:   tolerance      <= cfg_data[W-2:0];
        REG_MAX_ITER:    max_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The finish state loads the next item itself when the register empties.
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            lo    <= lower_end;
            hi    <= upper_end;
            steps <= '0;
            state <= S_EVAL_LO;
          end
        end
        S_EVAL_LO: begin
          if (eval_res.done) begin
            sa_zero <= eval_res.zero;
            sa_neg  <= eval_res.neg;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          steps <= steps + 1'b1;
          if (sa_zero) begin
            root  <= lo;
            ez    <= 1'b1;
            conv  <= 1'b0;
            state <= S_FINISH;
          end else begin
            state <= S_EVAL_MID;
          end
        end
        S_EVAL_MID: begin
          if (eval_res.done) begin
            if (eval_res.zero) begin
              root  <= mid;
              ez    <= 1'b1;
              conv  <= 1'b0;
              state <= S_FINISH;
            end else begin
              // Same sign as the lower end moves the lower end; otherwise the upper.
              if (eval_res.neg == sa_neg) begin
                lo <= mid;
              end else begin
                hi <= mid;
              end
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (wide && steps < max_iterations) begin
            state <= S_STEP;
          end else begin
            root  <= mid;
            ez    <= 1'b0;
            conv  <= ~wide;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            root_estimate <= root;
            exact_zero    <= ez;
            converged     <= conv;
            steps_used    <= steps;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(exact_zero && converged))
    else $error("result flags exact_zero and converged both set");

  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> steps_used != '0)
    else $error("result item carries zero steps");

  a_eval_expected: assert property (@(posedge clk) disable iff (rst)
    eval_res.done |-> (state == S_EVAL_LO || state == S_EVAL_MID))
    else $error("evaluation finished while no evaluation was awaited");

endmodule

// ----- verif/bisection_cubic_root_finder_test.sv -----
// Self-checking testbench for the bisection cubic root finder.
`timescale 1ns / 1ps

module bisection_cubic_root_finder_test;
  import bcr_pkg::*;

  localparam int LIMIT_CYCLES = 6000000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 115;

  typedef struct {
    logic signed [31:0] root;
    bit                 zero_hit;
    bit                 conv;
    bit [15:0]          steps;
  } root_result_t;

  typedef struct {
    logic signed [31:0] c3, c2, c1, c0;
    bit [31:0]          tol_data, iter_data;
  } poly_setting_t;

  typedef struct {
    int                 setting;
    logic signed [31:0] lo, hi;
    bit                 typed;
    root_result_t       want;
  } bracket_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] lower_end = '0;
  logic signed [31:0] upper_end = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] root_estimate;
  logic exact_zero;
  logic converged;
  logic [ITER_W-1:0] steps_used;

  // Shadow copy of the configuration registers.
  logic signed [31:0] k_cubic = RST_COEF_CUBIC;
  logic signed [31:0] k_square = RST_COEF_SQUARE;
  logic signed [31:0] k_linear = RST_COEF_LINEAR;
  logic signed [31:0] k_const = RST_COEF_CONST;
  bit [30:0] width_tol = 31'(RST_TOLERANCE);
  bit [15:0] step_limit = RST_MAX_ITER;

  root_result_t pending_roots[$];
  int errors = 0;
  int cycle_count = 0;
  int stall_hold = 0;

  bisection_cubic_root_finder dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls in held stretches, some of them with no stall at all.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold <= gap_len();
    end
  end

  // Sign of p(x), computed exactly in wide signed arithmetic.
  function automatic int poly_sign(longint x);
    logic signed [255:0] acc, xv, a3, a2, a1, a0;
    xv = x;
    a3 = k_cubic;
    a2 = k_square;
    a1 = k_linear;
    a0 = k_const;
    acc = a3 * xv;
    acc = (acc + (a2 <<< 16)) * xv;
    acc = (acc + (a1 <<< 32)) * xv;
    acc = acc + (a0 <<< 48);
    if (acc == 0) return 0;
    return acc[255] ? -1 : 1;
  endfunction

  function automatic longint span_of(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic root_result_t predict_root(logic signed [31:0] lo_in,
                                                logic signed [31:0] hi_in);
    root_result_t r;
    longint lo, hi, mid;
    int sa, sm;
    int unsigned steps;
    lo = lo_in;
    hi = hi_in;
    steps = 0;
    sa = poly_sign(lo);
    r.zero_hit = 0;
    r.conv = 0;
    do begin
      mid = (lo + hi) >>> 1;
      steps++;
      if (sa == 0) begin
        r.root = lo[31:0];
        r.zero_hit = 1;
        r.steps = steps[15:0];
        return r;
      end
      sm = poly_sign(mid);
      if (sm == 0) begin
        r.root = mid[31:0];
        r.zero_hit = 1;
        r.steps = steps[15:0];
        return r;
      end
      if (sm == sa) lo = mid;
      else hi = mid;
    end while (span_of(lo, hi) > longint'(width_tol) && steps < step_limit);
    mid = (lo + hi) >>> 1;
    r.root = mid[31:0];
    r.conv = (span_of(lo, hi) <= longint'(width_tol));
    r.steps = steps[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    root_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_roots.size() == 0) begin
        $error("result with no expectation: root_estimate %0d", root_estimate);
        errors++;
      end else begin
        e = pending_roots.pop_front();
        if (root_estimate !== e.root) begin
          $error("root_estimate expected %0d got %0d", e.root, root_estimate);
          errors++;
        end
        if (exact_zero !== e.zero_hit) begin
          $error("exact_zero expected %0d got %0d", e.zero_hit, exact_zero);
          errors++;
        end
        if (converged !== e.conv) begin
          $error("converged expected %0d got %0d", e.conv, converged);
          errors++;
        end
        if (steps_used !== e.steps) begin
          $error("steps_used expected %0d got %0d", e.steps, steps_used);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      REG_COEF_CUBIC: k_cubic = value;
      REG_COEF_SQUARE: k_square = value;
      REG_COEF_LINEAR: k_linear = value;
      REG_COEF_CONST: k_const = value;
      REG_TOLERANCE: width_tol = value[30:0];
      REG_MAX_ITER: step_limit = value[15:0];
      default: ;
    endcase
  endtask

  // Withdraws the input so that the last item is not offered again, then waits.
  task automatic drain();
    in_valid <= 0;
    while (pending_roots.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(poly_setting_t s);
    drain();
    write_reg(REG_COEF_CUBIC, s.c3);
    write_reg(REG_COEF_SQUARE, s.c2);
    write_reg(REG_COEF_LINEAR, s.c1);
    write_reg(REG_COEF_CONST, s.c0);
    write_reg(REG_TOLERANCE, s.tol_data);
    write_reg(REG_MAX_ITER, s.iter_data);
  endtask

  // Offers one bracket and waits until it is accepted.
  task automatic send_bracket(logic signed [31:0] lo, logic signed [31:0] hi,
                              bit typed, root_result_t want);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    lower_end <= lo;
    upper_end <= hi;
    in_valid <= 1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_roots.push_back(typed ? want : predict_root(lo, hi));
  endtask

  function automatic root_result_t res(logic signed [31:0] r, bit z, bit c, bit [15:0] n);
    root_result_t t;
    t.root = r;
    t.zero_hit = z;
    t.conv = c;
    t.steps = n;
    return t;
  endfunction

  function automatic logic signed [31:0] near_value(logic signed [31:0] base);
    longint v;
    v = longint'(base) + (longint'($urandom_range(0, 1 << $urandom_range(0, 24)))
        - longint'($urandom_range(0, 1 << $urandom_range(0, 24))));
    if (v > 64'sh7fffffff || v < -64'sh80000000) return $urandom;
    return v[31:0];
  endfunction

  initial begin
    poly_setting_t settings[5];
    bracket_row_t rows[$];
    root_result_t none;
    poly_setting_t s;
    logic signed [31:0] lo, hi, centre;
    int cur, kind;
    none = res(0, 0, 0, 0);

    settings[1] = '{0, 0, 0, 0, 32'd1, 32'd1000};
    settings[2] = '{0, 0, 32'sd65536, -32'sd196608, 32'd0, 32'd40};
    settings[3] = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                    32'h7fffffff, 32'd0};
    settings[4] = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                    32'h80000000, 32'd64};

    rows = '{
      '{0, 0, 0, 1, res(0, 0, 1, 1)},
      '{0, 32'sh80000000, 32'sh7fffffff, 0, none},
      '{0, 32'sh7fffffff, 32'sh80000000, 0, none},
      '{0, 0, 10 << 16, 0, none},
      '{0, 10 << 16, 0, 0, none},
      '{0, -1, 1, 0, none},
      '{1, 32'sh80000000, 5, 1, res(32'sh80000000, 1, 0, 1)},
      '{1, 7, -9, 1, res(7, 1, 0, 1)},
      '{2, 3 << 16, 5 << 16, 1, res(3 << 16, 1, 0, 1)},
      '{2, 2 << 16, 4 << 16, 1, res(3 << 16, 1, 0, 1)},
      '{2, 0, 7 << 16, 0, none},
      '{2, 32'sh7fffffff, 32'sh80000000, 0, none},
      '{3, 32'sh80000000, 32'sh7fffffff, 0, none},
      '{3, 5, 5, 0, none},
      '{4, 0, 1 << 16, 0, none},
      '{4, 32'sh80000000, 32'sh7fffffff, 0, none},
      '{4, -3, 32'sh40000000, 0, none}
    };

    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].setting != cur) begin
        cur = rows[i].setting;
        apply_setting(settings[cur]);
      end
      send_bracket(rows[i].lo, rows[i].hi, rows[i].typed, rows[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = p % 4;
      s.c3 = $urandom;
      s.c2 = $urandom;
      s.c1 = $urandom;
      s.c0 = $urandom;
      if (kind == 1) begin
        // Linear polynomial: its zero sits exactly at minus the constant.
        s.c3 = 0;
        s.c2 = 0;
        s.c1 = 32'sd65536;
        s.c0 = -($signed($urandom_range(0, 2000)) << $urandom_range(0, 14));
      end else if (kind == 2) begin
        s.c3 = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        s.c2 = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        s.c1 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        s.c0 = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      end else if (kind == 3) begin
        s.c3 = RST_COEF_CUBIC + $signed($urandom_range(0, 2000)) - 1000;
        s.c2 = RST_COEF_SQUARE;
        s.c1 = $signed($urandom_range(0, 4000)) - 2000;
        s.c0 = RST_COEF_CONST;
      end
      s.tol_data = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64);
      s.tol_data[31] = 1'($urandom_range(0, 1));
      if (s.tol_data[30:0] == 0) s.iter_data = $urandom_range(1, 64);
      else case ($urandom_range(0, 2))
        0: s.iter_data = $urandom_range(1, 40);
        1: s.iter_data = 1000;
        default: s.iter_data = 65535;
      endcase
      s.iter_data[31:16] = 16'($urandom);
      apply_setting(s);
      centre = (kind == 1) ? -s.c0 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && p == 3) drain();
        if ($urandom_range(0, 4) == 0) begin
          lo = $urandom;
          hi = $urandom;
        end else begin
          lo = ($urandom_range(0, 3) == 0) ? $urandom : near_value(centre);
          hi = near_value(lo);
        end
        send_bracket(lo, hi, 0, none);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bcr_pkg.sv
rtl/core/bcr_cell.sv
rtl/core/bcr_poly.sv
rtl/core/bisection_cubic_root_finder.sv
verif/bisection_cubic_root_finder_test.sv
